// ----- hw/rtl/ffpa_pkg.sv -----
package ffpa_pkg;

    // Default geometry of the pool.
    localparam int POOL_WORDS_DEF   = 1024;
    localparam int HEADER_WORDS_DEF = 1;
    localparam int WORD_BYTES_DEF   = 8;

    // Fixed field widths of the two channels.
    localparam int OP_W    = 2;
    localparam int REQ_W   = 14;
    localparam int PADDR_W = 10;
    localparam int AADDR_W = 10;
    localparam int LB_W    = 14;

    // Width of the rounded request (request plus word size minus one).
    localparam int NEED_W      = REQ_W + 1;
    // Shift of the reciprocal used to divide by the word size.
    localparam int RECIP_SHIFT = NEED_W;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_LARGEST = 2'd2,
        OP_RSVD    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOSPACE  = 2'd1,
        ST_NOTALLOC = 2'd2
    } status_t;

    typedef struct packed {
        op_t                op;
        logic [REQ_W-1:0]   request_bytes;
        logic [PADDR_W-1:0] payload_addr;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic [AADDR_W-1:0] alloc_addr;
        logic [LB_W-1:0]    largest_bytes;
    } res_t;

endpackage

// ----- hw/rtl/ffpa_hdr_mem.sv -----
module ffpa_hdr_mem #(
    parameter int POOL_WORDS = ffpa_pkg::POOL_WORDS_DEF,
    parameter int AW         = $clog2(POOL_WORDS),
    parameter int HW_W       = AW + 2
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   rd_en,
    input  logic [AW-1:0]          rd_addr,
    output logic signed [HW_W-1:0] rd_data,
    input  logic                   wr_en,
    input  logic [AW-1:0]          wr_addr,
    input  logic signed [HW_W-1:0] wr_data
);

    localparam logic [AW-1:0]   FIRST_ADDR = AW'(1);
    localparam logic [HW_W-1:0] FIRST_INIT = HW_W'(POOL_WORDS - 1);

    logic signed [HW_W-1:0] mem [0:POOL_WORDS-1];
    logic signed [HW_W-1:0] rd_data_reg;
    logic                   first_valid_reg;
    logic                   first_valid_next;
    logic                   use_init_reg;
    logic                   use_init_next;

    // Only the first header has a defined value after reset. Until it is
    // written, a read of it returns the header of the whole free pool.
    always_comb begin
        first_valid_next = first_valid_reg;
        use_init_next    = use_init_reg;
        if (wr_en && (wr_addr == FIRST_ADDR)) begin
            first_valid_next = 1'b1;
        end
        if (rd_en) begin
            use_init_next = (rd_addr == FIRST_ADDR) && !first_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_valid_reg <= 1'b0;
            use_init_reg    <= 1'b0;
        end else begin
            first_valid_reg <= first_valid_next;
            use_init_reg    <= use_init_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = use_init_reg ? signed'(FIRST_INIT) : rd_data_reg;

endmodule

// ----- hw/rtl/ffpa_walker.sv -----
module ffpa_walker #(
    parameter int POOL_WORDS   = ffpa_pkg::POOL_WORDS_DEF,
    parameter int HEADER_WORDS = ffpa_pkg::HEADER_WORDS_DEF,
    parameter int WORD_BYTES   = ffpa_pkg::WORD_BYTES_DEF,
    parameter int AW           = $clog2(POOL_WORDS),
    parameter int HW_W         = AW + 2
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  ffpa_pkg::cmd_t         cmd,
    output logic                   idle,
    output logic                   done,
    input  logic                   res_free,
    output ffpa_pkg::res_t         res,
    output logic                   rd_en,
    output logic [AW-1:0]          rd_addr,
    input  logic signed [HW_W-1:0] rd_data,
    output logic                   wr_en,
    output logic [AW-1:0]          wr_addr,
    output logic signed [HW_W-1:0] wr_data
);

    localparam int NX    = ffpa_pkg::NEED_W;
    localparam int RS    = ffpa_pkg::RECIP_SHIFT;
    localparam int RECIP = (1 << RS) / WORD_BYTES;
    localparam int CW    = (HW_W > NX + 1) ? HW_W : NX + 1;
    localparam int IW    = (HW_W > ffpa_pkg::PADDR_W + 1) ? HW_W : ffpa_pkg::PADDR_W + 1;
    localparam int LW    = (HW_W + 4 > ffpa_pkg::LB_W) ? HW_W + 4 : ffpa_pkg::LB_W;
    localparam int AAW   = (HW_W > ffpa_pkg::AADDR_W) ? HW_W : ffpa_pkg::AADDR_W;

    localparam logic [HW_W-1:0] POOL_END = HW_W'(POOL_WORDS);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_NMUL  = 13'b0000000000010,
        S_NFIX  = 13'b0000000000100,
        S_FCHK  = 13'b0000000001000,
        S_HRD   = 13'b0000000010000,
        S_HCHK  = 13'b0000000100000,
        S_MRD   = 13'b0000001000000,
        S_MCHK  = 13'b0000010000000,
        S_MEND  = 13'b0000100000000,
        S_SPLIT = 13'b0001000000000,
        S_CLAIM = 13'b0010000000000,
        S_FIN   = 13'b0100000000000,
        S_RESP  = 13'b1000000000000
    } state_t;

    state_t                 state_reg, state_next;
    ffpa_pkg::op_t          op_reg, op_next;
    logic [NX-1:0]          x_reg, x_next;
    logic [NX-1:0]          q_reg, q_next;
    logic [NX-1:0]          need_reg, need_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic [HW_W-1:0]        pos_reg, pos_next;
    logic [HW_W-1:0]        mpos_reg, mpos_next;
    logic [HW_W-1:0]        h_reg, h_next;
    logic [HW_W-1:0]        best_reg, best_next;
    ffpa_pkg::res_t         res_reg, res_next;

    // Shared position adder: every step along the chain goes through it.
    logic [HW_W-1:0]        add_a, add_b, add_sum;

    logic [2*NX-1:0]        prod;
    logic [NX-1:0]          rem;
    logic [IW-1:0]          pa_ext, free_idx;
    logic                   free_ok;
    logic                   h_pos;
    logic [HW_W-1:0]        h_abs, h_mag;
    logic                   h_ge_need;
    logic [HW_W-1:0]        merge_end, merge_total;
    logic                   total_ge_need;
    logic [CW-1:0]          split_pos;
    logic                   split_ok;
    logic [LW-1:0]          largest_w;
    logic [AAW-1:0]         addr_w;

    assign add_sum = add_a + add_b;

    assign prod = (2*NX)'(x_reg) * (2*NX)'(RECIP);
    assign rem  = x_reg - NX'(q_reg * NX'(WORD_BYTES));

    assign pa_ext   = IW'(cmd.payload_addr);
    assign free_idx = pa_ext - IW'(HEADER_WORDS);
    assign free_ok  = (pa_ext > IW'(HEADER_WORDS)) && (free_idx < IW'(POOL_WORDS));

    assign h_pos     = !rd_data[HW_W-1] && (rd_data != '0);
    assign h_abs     = rd_data[HW_W-1] ? HW_W'(-rd_data) : HW_W'(rd_data);
    assign h_mag     = (rd_data == '0) ? HW_W'(1) : h_abs;
    assign h_ge_need = signed'(CW'(rd_data)) >= signed'(CW'(need_reg));

    assign merge_end     = (mpos_reg >= POOL_END) ? POOL_END : mpos_reg;
    assign merge_total   = merge_end - pos_reg;
    assign total_ge_need = CW'(merge_total) >= CW'(need_reg);

    assign split_pos = CW'(pos_reg) + CW'(need_reg);
    assign split_ok  = (CW'(need_reg) < CW'(h_reg)) && (split_pos < CW'(POOL_WORDS));

    assign largest_w = LW'(best_reg - HW_W'(HEADER_WORDS)) * LW'(WORD_BYTES);
    assign addr_w    = AAW'(pos_reg) + AAW'(HEADER_WORDS);

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        x_next     = x_reg;
        q_next     = q_reg;
        need_next  = need_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        mpos_next  = mpos_reg;
        h_next     = h_reg;
        best_next  = best_reg;
        res_next   = res_reg;
        rd_en      = 1'b0;
        rd_addr    = pos_reg[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = pos_reg[AW-1:0];
        wr_data    = rd_data;
        add_a      = pos_reg;
        add_b      = h_mag;
        done       = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    op_next                = cmd.op;
                    x_next                 = NX'(cmd.request_bytes) + NX'(WORD_BYTES - 1);
                    pos_next               = HW_W'(1);
                    best_next              = '0;
                    idx_next               = free_idx[AW-1:0];
                    res_next.status        = ffpa_pkg::ST_OK;
                    res_next.alloc_addr    = '0;
                    res_next.largest_bytes = '0;
                    unique case (cmd.op)
                        ffpa_pkg::OP_ALLOC: begin
                            state_next = S_NMUL;
                        end
                        ffpa_pkg::OP_FREE: begin
                            if (free_ok) begin
                                rd_en      = 1'b1;
                                rd_addr    = free_idx[AW-1:0];
                                state_next = S_FCHK;
                            end else begin
                                res_next.status = ffpa_pkg::ST_NOTALLOC;
                                state_next      = S_RESP;
                            end
                        end
                        ffpa_pkg::OP_LARGEST: begin
                            state_next = S_HRD;
                        end
                        ffpa_pkg::OP_RSVD: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_NMUL: begin
                // The reciprocal estimate is exact or one below the quotient.
                q_next     = prod[RS+NX-1:RS];
                state_next = S_NFIX;
            end
            S_NFIX: begin
                need_next  = q_reg + NX'(rem >= NX'(WORD_BYTES)) + NX'(HEADER_WORDS);
                state_next = S_HRD;
            end
            S_FCHK: begin
                if (!rd_data[HW_W-1]) begin
                    res_next.status = ffpa_pkg::ST_NOTALLOC;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg;
                    wr_data = -rd_data;
                end
                state_next = S_RESP;
            end
            S_HRD: begin
                if (pos_reg >= POOL_END) begin
                    state_next = S_FIN;
                end else begin
                    rd_en      = 1'b1;
                    state_next = S_HCHK;
                end
            end
            S_HCHK: begin
                if ((op_reg == ffpa_pkg::OP_ALLOC) && h_ge_need) begin
                    h_next     = rd_data;
                    state_next = S_SPLIT;
                end else if (h_pos) begin
                    mpos_next  = add_sum;
                    state_next = S_MRD;
                end else begin
                    pos_next   = add_sum;
                    state_next = S_HRD;
                end
            end
            S_MRD: begin
                if (mpos_reg >= POOL_END) begin
                    state_next = S_MEND;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = mpos_reg[AW-1:0];
                    state_next = S_MCHK;
                end
            end
            S_MCHK: begin
                if (h_pos) begin
                    add_a      = mpos_reg;
                    add_b      = rd_data;
                    mpos_next  = add_sum;
                    state_next = S_MRD;
                end else begin
                    state_next = S_MEND;
                end
            end
            S_MEND: begin
                wr_en   = 1'b1;
                wr_data = signed'(merge_total);
                if ((op_reg == ffpa_pkg::OP_ALLOC) && total_ge_need) begin
                    h_next     = merge_total;
                    state_next = S_SPLIT;
                end else begin
                    pos_next = merge_end;
                    if (merge_total > best_reg) begin
                        best_next = merge_total;
                    end
                    state_next = S_HRD;
                end
            end
            S_SPLIT: begin
                if (split_ok) begin
                    wr_en   = 1'b1;
                    wr_addr = split_pos[AW-1:0];
                    wr_data = signed'(h_reg - HW_W'(need_reg));
                end
                state_next = S_CLAIM;
            end
            S_CLAIM: begin
                wr_en               = 1'b1;
                wr_data             = signed'(HW_W'(-HW_W'(need_reg)));
                res_next.alloc_addr = addr_w[ffpa_pkg::AADDR_W-1:0];
                state_next          = S_RESP;
            end
            S_FIN: begin
                if (op_reg == ffpa_pkg::OP_ALLOC) begin
                    res_next.status = ffpa_pkg::ST_NOSPACE;
                end else if (best_reg > HW_W'(HEADER_WORDS)) begin
                    res_next.largest_bytes = largest_w[ffpa_pkg::LB_W-1:0];
                end
                state_next = S_RESP;
            end
            S_RESP: begin
                done = 1'b1;
                if (res_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        x_reg    <= x_next;
        q_reg    <= q_next;
        need_reg <= need_next;
        idx_reg  <= idx_next;
        pos_reg  <= pos_next;
        mpos_reg <= mpos_next;
        h_reg    <= h_next;
        best_reg <= best_next;
        res_reg  <= res_next;
    end

    assign idle = (state_reg == S_IDLE);
    assign res  = res_reg;

endmodule

// ----- hw/rtl/first_fit_pool_allocator.sv -----
// First-fit pool allocator. The pool is a chain of block headers kept in a
// header memory with one read port and one write port; each header holds a
// signed size in words (positive is free, negative is allocated), and after
// reset one free block starts at word 1 and spans the whole pool. An input
// beat carries an operation: allocate rounds the byte request up to whole
// words, adds the header and walks first-fit from word 1, merging following
// free blocks into any free block too small for it, then splits the fitting
// block and returns its payload word index; free marks an allocated block
// free again; largest merges every run of free blocks and returns the
// biggest free payload in bytes. Each input beat produces exactly one result
// beat. The block handles one operation at a time and takes a new input beat
// only when idle, while a finished result may still wait in the output
// register. The header memory does one read per cycle. The reserved code
// goes straight to the result; free reads the header and, if the block is
// allocated, writes it back as free, then loads the result. Largest reads
// and checks each header it visits and, for each free block it meets,
// each header of its merge run up to the one that ends it, if any, then
// writes the merged size; a final step and the result load close the
// walk. Allocate first computes the size with a reciprocal multiply and a
// correction; it walks the same way up to the fitting block, then splits,
// claims and loads the result, or ends like largest when nothing fits.
// When the output register still holds an untaken beat, the finished
// result waits and the input stays stalled until that beat is taken. No
// clearing pass is needed after reset.
module first_fit_pool_allocator #(
    parameter int POOL_WORDS   = ffpa_pkg::POOL_WORDS_DEF,
    parameter int HEADER_WORDS = ffpa_pkg::HEADER_WORDS_DEF,
    parameter int WORD_BYTES   = ffpa_pkg::WORD_BYTES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [ffpa_pkg::OP_W-1:0]        s_op,
    input  logic [ffpa_pkg::REQ_W-1:0]       s_request_bytes,
    input  logic [ffpa_pkg::PADDR_W-1:0]     s_payload_addr,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_status,
    output logic [ffpa_pkg::AADDR_W-1:0]     m_alloc_addr,
    output logic [ffpa_pkg::LB_W-1:0]        m_largest_bytes
);

    localparam int AW   = $clog2(POOL_WORDS);
    localparam int HW_W = AW + 2;

    ffpa_pkg::cmd_t         cmd;
    ffpa_pkg::res_t         walk_res;
    ffpa_pkg::res_t         out_reg, out_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   walk_idle;
    logic                   walk_done;
    logic                   res_free;
    logic                   start;

    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic signed [HW_W-1:0] rd_data;
    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic signed [HW_W-1:0] wr_data;

    assign cmd.op            = ffpa_pkg::op_t'(s_op);
    assign cmd.request_bytes = s_request_bytes;
    assign cmd.payload_addr  = s_payload_addr;

    assign s_ready  = walk_idle;
    assign start    = s_valid && s_ready;

    // The output register frees up in the same cycle its beat is taken.
    assign res_free = !m_valid_reg || m_ready;

    ffpa_hdr_mem #(
        .POOL_WORDS (POOL_WORDS),
        .AW         (AW),
        .HW_W       (HW_W)
    ) u_hdr_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    ffpa_walker #(
        .POOL_WORDS   (POOL_WORDS),
        .HEADER_WORDS (HEADER_WORDS),
        .WORD_BYTES   (WORD_BYTES),
        .AW           (AW),
        .HW_W         (HW_W)
    ) u_walker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .cmd      (cmd),
        .idle     (walk_idle),
        .done     (walk_done),
        .res_free (res_free),
        .res      (walk_res),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    // Result register: loaded when the walker finishes and the register is
    // free, cleared when the downstream side takes the beat.
    always_comb begin
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (walk_done && res_free) begin
            out_next     = walk_res;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = out_reg.status;
    assign m_alloc_addr    = out_reg.alloc_addr;
    assign m_largest_bytes = out_reg.largest_bytes;

    // Once an operation is accepted, the block stays busy for at least the
    // next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an operation was in progress");

    // A new result beat only appears after the walker finished an operation.
    a_result_from_walker: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(walk_done))
        else $error("result beat without a finished operation");

    // A failed operation never reports a block address.
    a_fail_no_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ffpa_pkg::ST_OK)) |-> (m_alloc_addr == '0))
        else $error("failed operation reported a block address");

    // A largest-payload figure is only reported with a good status.
    a_largest_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_largest_bytes != '0)) |-> (m_status == ffpa_pkg::ST_OK))
        else $error("largest payload reported with an error status");

endmodule

// ----- dv/tb_first_fit_pool_allocator.sv -----
module tb_first_fit_pool_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    // Pool geometry used by the instance and by the local prediction.
    localparam int POOL_WORDS   = ffpa_pkg::POOL_WORDS_DEF;
    localparam int HEADER_WORDS = ffpa_pkg::HEADER_WORDS_DEF;
    localparam int WORD_BYTES   = ffpa_pkg::WORD_BYTES_DEF;

    // The watchdog limit lies well above the longest walk over a fragmented
    // pool and above the receiver hold-off.
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES    = 64;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic [ffpa_pkg::OP_W-1:0]        s_op = ffpa_pkg::OP_ALLOC;
    logic [ffpa_pkg::REQ_W-1:0]       s_request_bytes = '0;
    logic [ffpa_pkg::PADDR_W-1:0]     s_payload_addr = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic [1:0]                       m_status;
    logic [ffpa_pkg::AADDR_W-1:0]     m_alloc_addr;
    logic [ffpa_pkg::LB_W-1:0]        m_largest_bytes;

    first_fit_pool_allocator #(
        .POOL_WORDS  (POOL_WORDS),
        .HEADER_WORDS(HEADER_WORDS),
        .WORD_BYTES  (WORD_BYTES)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_request_bytes(s_request_bytes),
        .s_payload_addr (s_payload_addr),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_alloc_addr   (m_alloc_addr),
        .m_largest_bytes(m_largest_bytes)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Local copy of the pool. Every header holds a signed size in words;
    // positive is free, negative is allocated. hdr_written marks entries
    // that the block has really written, since freeing a payload whose
    // header was never written would read undefined memory.
    // ------------------------------------------------------------------
    int                 pool_hdr [POOL_WORDS];
    bit                 hdr_written [POOL_WORDS];
    int                 written_hdrs[$];
    int                 live_payloads[$];
    ffpa_pkg::res_t     pending_results[$];

    ffpa_pkg::status_t  last_status;
    bit                 idle_off = 1'b0;
    int                 errors = 0;
    int                 results_seen = 0;
    int                 beats_sent = 0;
    int                 n_granted = 0;
    int                 n_nospace = 0;
    int                 n_freed = 0;
    int                 n_rejected = 0;
    int                 n_largest = 0;

    // Receiver hold-off request: the test bumps rx_hold_req, the receiver
    // process notices the change and runs the hold-off set by rx_hold_len on its own.
    int       rx_hold_req = 0;
    int       rx_hold_len = 0;
    int       rx_hold_ack;
    int       rx_stall_left;
    int       quiet_cycles = 0;

    function automatic void set_hdr(int idx, int val);
        pool_hdr[idx] = val;
        if (!hdr_written[idx]) begin
            hdr_written[idx] = 1'b1;
            written_hdrs.push_back(idx);
        end
    endfunction

    // Distance to the next header; a zero header still advances one word.
    function automatic int hdr_span(int val);
        int a;
        a = (val < 0) ? -val : val;
        return (a == 0) ? 1 : a;
    endfunction

    // Absorb the run of free blocks that follows a free block. The merged
    // size never reaches past the pool end.
    function automatic void coalesce_from(int origin);
        int p;
        int added;
        int total;
        int h;
        p = origin + pool_hdr[origin];
        added = 0;
        if (pool_hdr[origin] < 0)
            return;
        while (p < POOL_WORDS && p > origin) begin
            h = pool_hdr[p];
            if (h <= 0)
                break;
            added += h;
            p += h;
        end
        total = pool_hdr[origin] + added;
        if (total > POOL_WORDS - origin)
            total = POOL_WORDS - origin;
        set_hdr(origin, total);
    endfunction

    function automatic void reset_pool();
        foreach (pool_hdr[i]) begin
            pool_hdr[i] = 0;
            hdr_written[i] = 1'b0;
        end
        written_hdrs.delete();
        live_payloads.delete();
        set_hdr(1, POOL_WORDS - 1);
    endfunction

    // Apply one command beat to the local pool and return the result beat
    // the block must produce for it.
    function automatic ffpa_pkg::res_t pool_apply(ffpa_pkg::op_t op,
                                                  logic [ffpa_pkg::REQ_W-1:0] rq,
                                                  logic [ffpa_pkg::PADDR_W-1:0] pa);
        ffpa_pkg::res_t r;
        int need;
        int pos;
        int found;
        int h;
        int idx;
        int best;
        r.status = ffpa_pkg::ST_OK;
        r.alloc_addr = '0;
        r.largest_bytes = '0;
        case (op)
            ffpa_pkg::OP_ALLOC: begin
                need = (int'(rq) + WORD_BYTES - 1) / WORD_BYTES + HEADER_WORDS;
                pos = 1;
                found = 0;
                while (pos < POOL_WORDS) begin
                    h = pool_hdr[pos];
                    if (h >= 0 && h < need) begin
                        coalesce_from(pos);
                        h = pool_hdr[pos];
                    end
                    if (h >= 0 && h >= need) begin
                        found = pos;
                        break;
                    end
                    pos += hdr_span(h);
                end
                if (found == 0) begin
                    r.status = ffpa_pkg::ST_NOSPACE;
                    n_nospace++;
                end else begin
                    h = pool_hdr[found];
                    // An exact fit takes the block whole; otherwise split.
                    if (need < h && found + need < POOL_WORDS)
                        set_hdr(found + need, h - need);
                    set_hdr(found, -need);
                    // A payload right at the pool end wraps to zero.
                    r.alloc_addr = ffpa_pkg::AADDR_W'(found + HEADER_WORDS);
                    if (r.alloc_addr != 0)
                        live_payloads.push_back(int'(r.alloc_addr));
                    n_granted++;
                end
            end
            ffpa_pkg::OP_FREE: begin
                idx = int'(pa) - HEADER_WORDS;
                if (idx < 1 || idx >= POOL_WORDS || pool_hdr[idx] >= 0) begin
                    r.status = ffpa_pkg::ST_NOTALLOC;
                    n_rejected++;
                end else begin
                    set_hdr(idx, -pool_hdr[idx]);
                    foreach (live_payloads[i]) begin
                        if (live_payloads[i] == int'(pa)) begin
                            live_payloads.delete(i);
                            break;
                        end
                    end
                    n_freed++;
                end
            end
            ffpa_pkg::OP_LARGEST: begin
                pos = 1;
                best = 0;
                while (pos < POOL_WORDS) begin
                    coalesce_from(pos);
                    h = pool_hdr[pos];
                    if (h > best)
                        best = h;
                    pos += hdr_span(h);
                end
                if (best > HEADER_WORDS)
                    r.largest_bytes = ffpa_pkg::LB_W'((best - HEADER_WORDS) * WORD_BYTES);
                n_largest++;
            end
            default: begin
                // The reserved code changes nothing and reports all zeros.
            end
        endcase
        return r;
    endfunction

    // Idle lengths: mostly short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom_range(1, 3);
        else if (r < 9)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // Sender. Valid goes high with the payload and stays until the beat is
    // accepted. It is only lowered when an idle gap follows, so a back to
    // back beat never sees valid lowered and raised in one time step.
    // ------------------------------------------------------------------
    task automatic send_cmd(input ffpa_pkg::op_t op,
                            input logic [ffpa_pkg::REQ_W-1:0] rq,
                            input logic [ffpa_pkg::PADDR_W-1:0] pa);
        int gap;
        ffpa_pkg::res_t r;
        gap = 0;
        if (!idle_off && $urandom_range(0, 2) == 0)
            gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_op            <= op;
        s_request_bytes <= rq;
        s_payload_addr  <= pa;
        do
            @(posedge aclk);
        while (!s_ready);
        // Accepted at this edge; predict in acceptance order.
        r = pool_apply(op, rq, pa);
        last_status = r.status;
        pending_results.push_back(r);
        beats_sent++;
    endtask

    // Stop offering beats until every predicted result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (pending_results.size() != 0);
    endtask

    function automatic logic [ffpa_pkg::REQ_W-1:0] any_request();
        return ffpa_pkg::REQ_W'($urandom_range(0, 8192));
    endfunction

    function automatic logic [ffpa_pkg::PADDR_W-1:0] any_addr();
        return ffpa_pkg::PADDR_W'($urandom_range(0, POOL_WORDS - 1));
    endfunction

    // One random command beat. Allocations and frees of live blocks make
    // up most of the traffic so that the chain fragments and the walks get
    // long; the rest are frees of any written header or a bad address, largest reports and the reserved code.
    task automatic send_random_beat();
        int r;
        int sz;
        int free_share;
        logic [ffpa_pkg::REQ_W-1:0] rq;
        r = $urandom_range(0, 99);
        free_share = (live_payloads.size() > 48) ? 42 : 30;
        if (r < 44 || (r < 44 + free_share && live_payloads.size() == 0)) begin
            sz = $urandom_range(0, 9);
            if (sz < 6)
                rq = ffpa_pkg::REQ_W'($urandom_range(1, 256));
            else if (sz < 8)
                rq = ffpa_pkg::REQ_W'($urandom_range(0, 16));
            else if (sz < 9)
                rq = ffpa_pkg::REQ_W'($urandom_range(257, 2048));
            else
                rq = ffpa_pkg::REQ_W'($urandom_range(2049, 8192));
            send_cmd(ffpa_pkg::OP_ALLOC, rq, any_addr());
        end else if (r < 44 + free_share) begin
            send_cmd(ffpa_pkg::OP_FREE, any_request(),
                     ffpa_pkg::PADDR_W'(live_payloads[$urandom_range(0,
                                        live_payloads.size() - 1)]));
        end else if (r < 50 + free_share) begin
            // Any header that was ever written: free, stale or allocated.
            send_cmd(ffpa_pkg::OP_FREE, any_request(),
                     ffpa_pkg::PADDR_W'(written_hdrs[$urandom_range(0,
                                        written_hdrs.size() - 1)] + HEADER_WORDS));
        end else if (r < 52 + free_share) begin
            send_cmd(ffpa_pkg::OP_FREE, any_request(),
                     ffpa_pkg::PADDR_W'($urandom_range(0, HEADER_WORDS)));
        end else if (r < 99) begin
            send_cmd(ffpa_pkg::OP_LARGEST, any_request(), any_addr());
        end else begin
            send_cmd(ffpa_pkg::OP_RSVD, any_request(), any_addr());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Directed corners: the whole pool, requests that can never fit, a free
    // block no larger than its header, a payload at the pool end that wraps
    // to zero, bad frees, the reserved code, exact fits after a merge, and
    // merges that stay in place although the walk fails.
    task automatic test_directed_corners();
        send_cmd(ffpa_pkg::OP_LARGEST, '0, '0);
        send_cmd(ffpa_pkg::OP_ALLOC, ffpa_pkg::REQ_W'(8192), '0);
        send_cmd(ffpa_pkg::OP_ALLOC, ffpa_pkg::REQ_W'(8168), '0);
        send_cmd(ffpa_pkg::OP_LARGEST, '0, '0);
        send_cmd(ffpa_pkg::OP_ALLOC, '0, '0);
        send_cmd(ffpa_pkg::OP_ALLOC, ffpa_pkg::REQ_W'(1), '0);
        send_cmd(ffpa_pkg::OP_FREE, '0, ffpa_pkg::PADDR_W'(0));
        send_cmd(ffpa_pkg::OP_FREE, '0, ffpa_pkg::PADDR_W'(1));
        send_cmd(ffpa_pkg::OP_FREE, '0, ffpa_pkg::PADDR_W'(2));
        send_cmd(ffpa_pkg::OP_FREE, '0, ffpa_pkg::PADDR_W'(2));
        send_cmd(ffpa_pkg::OP_RSVD, ffpa_pkg::REQ_W'(8192), ffpa_pkg::PADDR_W'(1023));
        send_cmd(ffpa_pkg::OP_ALLOC, ffpa_pkg::REQ_W'(1), '0);
        send_cmd(ffpa_pkg::OP_ALLOC, ffpa_pkg::REQ_W'(8), '0);
        send_cmd(ffpa_pkg::OP_ALLOC, ffpa_pkg::REQ_W'(7), '0);
        send_cmd(ffpa_pkg::OP_FREE, '0, ffpa_pkg::PADDR_W'(2));
        send_cmd(ffpa_pkg::OP_FREE, '0, ffpa_pkg::PADDR_W'(4));
        send_cmd(ffpa_pkg::OP_ALLOC, ffpa_pkg::REQ_W'(24), '0);
        send_cmd(ffpa_pkg::OP_FREE, '0, ffpa_pkg::PADDR_W'(2));
        send_cmd(ffpa_pkg::OP_FREE, '0, ffpa_pkg::PADDR_W'(6));
        send_cmd(ffpa_pkg::OP_ALLOC, ffpa_pkg::REQ_W'(8176), '0);
        send_cmd(ffpa_pkg::OP_LARGEST, '0, '0);
        send_cmd(ffpa_pkg::OP_ALLOC, ffpa_pkg::REQ_W'(16), '0);
        send_cmd(ffpa_pkg::OP_ALLOC, ffpa_pkg::REQ_W'(8191), ffpa_pkg::PADDR_W'(1023));
        send_cmd(ffpa_pkg::OP_FREE, ffpa_pkg::REQ_W'(8191), ffpa_pkg::PADDR_W'(2));
    endtask

    // Fill the pool with blocks of a given size range until one is refused or
    // 300 were sent, release every block in random order, then merge it all.
    task automatic test_fill_and_release(input int lo, input int hi);
        int n;
        n = 0;
        do begin
            send_cmd(ffpa_pkg::OP_ALLOC, ffpa_pkg::REQ_W'($urandom_range(lo, hi)),
                     any_addr());
            n++;
        end while (last_status != ffpa_pkg::ST_NOSPACE && n < 300);
        while (live_payloads.size() > 0)
            send_cmd(ffpa_pkg::OP_FREE, any_request(),
                     ffpa_pkg::PADDR_W'(live_payloads[$urandom_range(0,
                                        live_payloads.size() - 1)]));
        send_cmd(ffpa_pkg::OP_LARGEST, any_request(), any_addr());
    endtask

    task automatic test_random_mix(input int count);
        repeat (count) send_random_beat();
    endtask

    // Back to back beats with neither side idling.
    task automatic test_no_idle_burst(input int count);
        idle_off = 1'b1;
        repeat (count) send_random_beat();
        idle_off = 1'b0;
    endtask

    // The receiver stops taking results for a long stretch while beats keep
    // coming, so the block backs up and stalls its input.
    task automatic test_receiver_holdoff();
        rx_hold_len = RX_HOLD_CYCLES;
        rx_hold_req++;
        repeat (12) send_random_beat();
    endtask

    // The sender goes quiet until everything outstanding has returned.
    task automatic test_pause_until_drained();
        repeat (10) send_random_beat();
        wait_drained();
        repeat (10) send_random_beat();
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus the long hold-off on request.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_stall_left = 0;
            rx_hold_ack = 0;
        end else if (rx_hold_ack != rx_hold_req) begin
            rx_hold_ack = rx_hold_req;
            rx_stall_left = rx_hold_len - 1;
            m_ready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left--;
            m_ready <= 1'b0;
        end else if (!idle_off && $urandom_range(0, 3) == 0) begin
            rx_stall_left = pick_gap() - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Result checker: each accepted result beat against the oldest
    // prediction, field by field.
    always @(posedge aclk) begin : result_check
        ffpa_pkg::res_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result beat with none predicted: status %0d addr %0d largest %0d",
                         $time, m_status, m_alloc_addr, m_largest_bytes);
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status) begin
                    errors++;
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.status, m_status);
                end
                if (m_alloc_addr !== want.alloc_addr) begin
                    errors++;
                    $display("%0t: alloc_addr mismatch: expected %0d actual %0d",
                             $time, want.alloc_addr, m_alloc_addr);
                end
                if (m_largest_bytes !== want.largest_bytes) begin
                    errors++;
                    $display("%0t: largest_bytes mismatch: expected %0d actual %0d",
                             $time, want.largest_bytes, m_largest_bytes);
                end
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either channel for too
    // long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, pending_results.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        reset_pool();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_corners();
        test_random_mix(360);
        test_fill_and_release(64, 1024);
        test_receiver_holdoff();
        test_fill_and_release(16, 96);
        test_no_idle_burst(120);
        test_pause_until_drained();
        test_fill_and_release(0, 4096);
        test_random_mix(300);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d command beats: %0d grants, %0d refused for space, %0d frees,",
                 beats_sent, n_granted, n_nospace, n_freed);
        $display("%0d rejected frees, %0d largest reports; %0d results checked, %0d mismatches.",
                 n_rejected, n_largest, results_seen, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/ffpa_pkg.sv
hw/rtl/ffpa_hdr_mem.sv
hw/rtl/ffpa_walker.sv
hw/rtl/first_fit_pool_allocator.sv
dv/tb_first_fit_pool_allocator.sv
